/* sv/svis_pkg.sv */
// svis_pkg: item types, configuration bundle and fixed constants
// for the SPH viscosity accumulator. No dependencies.
package svis_pkg;

    localparam int NUM_CFG = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MASS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFF  = 2'd3;

    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] rel_x;
        logic signed [31:0] rel_y;
        logic signed [31:0] rel_z;
        logic signed [31:0] dvel_x;
        logic signed [31:0] dvel_y;
        logic signed [31:0] dvel_z;
        logic [30:0]        density_nb;
        logic [30:0]        density_self;
        logic               last_pair;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [30:0] mass;
        logic [30:0] radius;
        logic [30:0] gain;
        logic [30:0] coeff;
    } cfg_t;

    // one pair after the front end: magnitudes and signs split out
    typedef struct packed {
        logic [2:0][31:0] rmag;
        logic [2:0][31:0] vmag;
        logic [2:0]       vneg;
        logic [30:0]      rho_n;
        logic [30:0]      rho_s;
        logic             last;
    } q_entry_t;

endpackage

/* sv/svis_front.sv */
// svis_front: accepts pair items, splits magnitude and sign, and queues
// them two deep for the back end. Depends on svis_pkg.
module svis_front import svis_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    input  logic      pop,
    output logic      q_valid,
    output q_entry_t  q_head
);

    q_entry_t   mem_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    q_entry_t   ent;

    function automatic logic [31:0] mag32(input logic [31:0] raw);
        mag32 = raw[31] ? 32'(-raw) : raw;
    endfunction

    always_comb
    begin
        ent.rmag[0] = mag32(in_data.rel_x);
        ent.rmag[1] = mag32(in_data.rel_y);
        ent.rmag[2] = mag32(in_data.rel_z);
        ent.vmag[0] = mag32(in_data.dvel_x);
        ent.vmag[1] = mag32(in_data.dvel_y);
        ent.vmag[2] = mag32(in_data.dvel_z);
        ent.vneg    = {in_data.dvel_z[31], in_data.dvel_y[31], in_data.dvel_x[31]};
        ent.rho_n   = in_data.density_nb;
        ent.rho_s   = in_data.density_self;
        ent.last    = in_data.last_pair;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_head   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= ent;
        end
    end

endmodule

/* sv/svis_sqrt.sv */
// svis_sqrt: 64-bit integer square root, one result bit per cycle.
// Depends on svis_pkg.
module svis_sqrt import svis_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [63:0] v_reg, v_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = value;
            res_next  = 64'd0;
            bit_next  = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg == 64'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

/* sv/svis_div.sv */
// svis_div: restoring divider, one quotient bit per cycle, 31-bit divisor.
// Depends on svis_pkg.
module svis_div import svis_pkg::*;
#(
    parameter int SH_W = 47
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [30:0]                 rem0,
    input  logic [SH_W-1:0]             bits,
    input  logic [$clog2(SH_W+1)-1:0]   count,
    input  logic [30:0]                 divisor,
    output logic                        done,
    output logic [SH_W-1:0]             quot
);

    localparam int CNT_W = $clog2(SH_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [30:0]      rem_reg, rem_next;
    logic [30:0]      dvs_reg, dvs_next;
    logic [SH_W-1:0]  sh_reg, sh_next;
    logic [SH_W-1:0]  q_reg, q_next;
    logic [31:0]      rem2;
    logic             ge;

    assign rem2 = {rem_reg, sh_reg[SH_W-1]};
    assign ge   = (rem2 >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = count;
            rem_next  = rem0;
            dvs_next  = divisor;
            sh_next   = bits;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 31'(rem2 - {1'b0, dvs_reg}) : rem2[30:0];
            q_next   = {q_reg[SH_W-2:0], ge};
            sh_next  = sh_reg << 1;
            cnt_next = CNT_W'(cnt_reg - 1'b1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* sv/svis_back.sv */
// svis_back: sequencer that turns queued pairs into kernel terms, keeps the
// running sums and produces the result. Depends on svis_pkg, svis_sqrt, svis_div.
module svis_back import svis_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int ACC_BITS  = 48
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    input  q_entry_t  q_head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int SH_W  = 31 + FRAC_BITS;
    localparam int CNT_W = $clog2(SH_W + 1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQ0  = 5'd1;
    localparam logic [4:0] S_SQ1  = 5'd2;
    localparam logic [4:0] S_SQ2  = 5'd3;
    localparam logic [4:0] S_SQ3  = 5'd4;
    localparam logic [4:0] S_CMP  = 5'd5;
    localparam logic [4:0] S_SQRT = 5'd6;
    localparam logic [4:0] S_W    = 5'd7;
    localparam logic [4:0] S_T1I  = 5'd8;
    localparam logic [4:0] S_T1   = 5'd9;
    localparam logic [4:0] S_DIV  = 5'd10;
    localparam logic [4:0] S_T3I  = 5'd11;
    localparam logic [4:0] S_T3   = 5'd12;
    localparam logic [4:0] S_LAST = 5'd13;
    localparam logic [4:0] S_F0   = 5'd14;
    localparam logic [4:0] S_F1   = 5'd15;
    localparam logic [4:0] S_F2   = 5'd16;
    localparam logic [4:0] S_FDIV = 5'd17;
    localparam logic [4:0] S_EMIT = 5'd18;

    localparam logic signed [ACC_BITS-1:0] SUM_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SUM_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic [4:0]                 state_reg, state_next;
    q_entry_t                   cur_reg, cur_next;
    logic [63:0]                r2_reg, r2_next;
    logic [30:0]                w_reg, w_next;
    logic [30:0]                t2_reg, t2_next;
    logic [1:0]                 axis_reg, axis_next;
    logic signed [ACC_BITS-1:0] sum_reg [3];
    logic signed [ACC_BITS-1:0] sum_next [3];
    logic                       sat_reg, sat_next;
    logic                       fin_reg, fin_next;
    logic [31:0]                res_reg [3];
    logic [31:0]                res_next [3];
    logic [63:0]                plo_reg, plo_next;
    logic [63:0]                mul_p_reg;
    logic                       out_valid_reg, out_valid_next;
    out_item_t                  out_data_reg, out_data_next;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       psh;
    logic [30:0]       pcap;
    logic              pcap_hit;
    logic              sqrt_start, sqrt_done;
    logic [31:0]       sqrt_root;
    logic              div_start, div_done;
    logic [30:0]       div_rem0, div_dvs;
    logic [SH_W-1:0]   div_bits, div_quot;
    logic [CNT_W-1:0]  div_count;

    logic signed [ACC_BITS-1:0] s_cur;
    logic                       s_neg;
    logic [ACC_BITS-1:0]        s_mag;
    logic [63:0]                mag64;
    logic [95:0]                pbig, pp, lim;
    logic [30:0]                qsel;
    logic                       qstore;
    logic signed [31:0]         term;
    logic signed [ACC_BITS:0]   sum_ext;
    logic [30:0]                rad_diff;

    // shared multiplier, product registered
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_a * mul_b;
    end

    assign psh      = mul_p_reg >> FRAC_BITS;
    assign pcap_hit = |psh[63:31];
    assign pcap     = pcap_hit ? MAX31 : psh[30:0];

    assign s_cur    = sum_reg[axis_reg];
    assign s_neg    = s_cur[ACC_BITS-1];
    assign s_mag    = s_neg ? ACC_BITS'(-s_cur) : ACC_BITS'(s_cur);
    assign mag64    = 64'(s_mag);
    assign pbig     = {32'd0, plo_reg} + {mul_p_reg, 32'd0};
    assign pp       = pbig >> FRAC_BITS;
    assign lim      = 96'(cur_reg.rho_s) << (31 - FRAC_BITS);
    assign rad_diff = 31'(cfg.radius - sqrt_root[30:0]);

    svis_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (r2_reg),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    svis_div #(.SH_W(SH_W)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .rem0    (div_rem0),
        .bits    (div_bits),
        .count   (div_count),
        .divisor (div_dvs),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        r2_next        = r2_reg;
        w_next         = w_reg;
        t2_next        = t2_reg;
        axis_next      = axis_reg;
        sat_next       = sat_reg;
        fin_next       = fin_reg;
        plo_next       = plo_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i] = sum_reg[i];
            res_next[i] = res_reg[i];
        end
        pop        = 1'b0;
        mul_a      = 32'd0;
        mul_b      = 32'd0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        div_rem0   = 31'd0;
        div_bits   = '0;
        div_count  = CNT_W'(SH_W);
        div_dvs    = cur_reg.rho_n;
        qsel       = 31'd0;
        qstore     = 1'b0;
        term       = '0;
        sum_ext    = '0;

        // drop the output item once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop        = 1'b1;
                    cur_next   = q_head;
                    r2_next    = 64'd0;
                    state_next = S_SQ0;
                end
            end
            S_SQ0:
            begin
                mul_a      = cur_reg.rmag[0];
                mul_b      = cur_reg.rmag[0];
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                mul_a      = cur_reg.rmag[1];
                mul_b      = cur_reg.rmag[1];
                r2_next    = mul_p_reg;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                mul_a      = cur_reg.rmag[2];
                mul_b      = cur_reg.rmag[2];
                r2_next    = r2_reg + mul_p_reg;
                state_next = S_SQ3;
            end
            S_SQ3:
            begin
                mul_a      = {1'b0, cfg.radius};
                mul_b      = {1'b0, cfg.radius};
                r2_next    = r2_reg + mul_p_reg;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (r2_reg < mul_p_reg)
                begin
                    sqrt_start = 1'b1;
                    state_next = S_SQRT;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end
            S_SQRT:
            begin
                mul_a = {1'b0, cfg.coeff};
                mul_b = {1'b0, rad_diff};
                if (sqrt_done)
                begin
                    state_next = S_W;
                end
            end
            S_W:
            begin
                w_next     = pcap;
                sat_next   = sat_reg | pcap_hit;
                axis_next  = 2'd0;
                state_next = S_T1I;
            end
            S_T1I:
            begin
                mul_a      = {1'b0, cfg.mass};
                mul_b      = cur_reg.vmag[axis_reg];
                state_next = S_T1;
            end
            S_T1:
            begin
                sat_next = sat_reg | pcap_hit;
                if (cur_reg.rho_n == 31'd0)
                begin
                    // zero neighbor density: full scale with the sign of dv
                    sat_next   = 1'b1;
                    t2_next    = (cur_reg.vmag[axis_reg] != 32'd0) ? MAX31 : 31'd0;
                    state_next = S_T3I;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_bits   = SH_W'(pcap) << FRAC_BITS;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    t2_next    = (|div_quot[SH_W-1:31]) ? MAX31 : div_quot[30:0];
                    sat_next   = sat_reg | (|div_quot[SH_W-1:31]);
                    state_next = S_T3I;
                end
            end
            S_T3I:
            begin
                mul_a      = {1'b0, t2_reg};
                mul_b      = {1'b0, w_reg};
                state_next = S_T3;
            end
            S_T3:
            begin
                term    = cur_reg.vneg[axis_reg] ? -$signed({1'b0, pcap})
                                                 : $signed({1'b0, pcap});
                sum_ext = {s_cur[ACC_BITS-1], s_cur}
                        + {{(ACC_BITS-31){term[31]}}, term};
                if (sum_ext[ACC_BITS] != sum_ext[ACC_BITS-1])
                begin
                    sum_next[axis_reg] = sum_ext[ACC_BITS] ? SUM_MIN : SUM_MAX;
                    sat_next           = 1'b1;
                end
                else
                begin
                    sum_next[axis_reg] = sum_ext[ACC_BITS-1:0];
                    sat_next           = sat_reg | pcap_hit;
                end
                if (pcap_hit)
                begin
                    sat_next = 1'b1;
                end
                if (axis_reg == 2'd2)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    axis_next  = 2'(axis_reg + 1'b1);
                    state_next = S_T1I;
                end
            end
            S_LAST:
            begin
                if (cur_reg.last)
                begin
                    axis_next  = 2'd0;
                    fin_next   = 1'b0;
                    state_next = S_F0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_F0:
            begin
                mul_a = {1'b0, cfg.gain};
                mul_b = mag64[31:0];
                if (cur_reg.rho_s == 31'd0)
                begin
                    fin_next = 1'b1;
                    qsel     = (s_mag != '0) ? MAX31 : 31'd0;
                    qstore   = 1'b1;
                end
                else
                begin
                    state_next = S_F1;
                end
            end
            S_F1:
            begin
                mul_a      = {1'b0, cfg.gain};
                mul_b      = mag64[63:32];
                plo_next   = mul_p_reg;
                state_next = S_F2;
            end
            S_F2:
            begin
                if (pp >= lim)
                begin
                    fin_next = 1'b1;
                    qsel     = MAX31;
                    qstore   = 1'b1;
                end
                else
                begin
                    // quotient fits 31 bits: start from the top part as remainder
                    div_start  = 1'b1;
                    div_dvs    = cur_reg.rho_s;
                    div_rem0   = 31'(pp >> (31 - FRAC_BITS));
                    div_bits   = {31'(pp << FRAC_BITS), {(SH_W-31){1'b0}}};
                    div_count  = CNT_W'(31);
                    state_next = S_FDIV;
                end
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    qsel   = div_quot[30:0];
                    qstore = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next.acc_x     = res_reg[0];
                    out_data_next.acc_y     = res_reg[1];
                    out_data_next.acc_z     = res_reg[2];
                    out_data_next.saturated = fin_reg | sat_reg;
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_next[i] = '0;
                    end
                    sat_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // store one finished axis, advance to the next
        if (qstore)
        begin
            res_next[axis_reg] = s_neg ? 32'(-{1'b0, qsel}) : {1'b0, qsel};
            if (axis_reg == 2'd2)
            begin
                state_next = S_EMIT;
            end
            else
            begin
                axis_next  = 2'(axis_reg + 1'b1);
                state_next = S_F0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            sat_reg       <= 1'b0;
            fin_reg       <= 1'b0;
            axis_reg      <= 2'd0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sat_reg       <= sat_next;
            fin_reg       <= fin_next;
            axis_reg      <= axis_next;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        r2_reg       <= r2_next;
        w_reg        <= w_next;
        t2_reg       <= t2_next;
        plo_reg      <= plo_next;
        out_data_reg <= out_data_next;
        for (int i = 0; i < 3; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/sph_viscosity_accumulate_core.sv */
// sph_viscosity_accumulate_core: top level of the SPH viscosity accumulator.
// Depends on svis_pkg, svis_front, svis_back (with svis_sqrt, svis_div).
//
//  channel | signals                          | item
//  --------+----------------------------------+-------------------------------
//  in      | in_valid, in_stall, in_data      | one particle-neighbor pair
//  out     | out_valid, out_stall, out_data   | acceleration on the last pair
//  cfg     | cfg_en, cfg_index, cfg_data      | register write, no handshake
//
// Back end: a pair outside the support skips the kernel terms. A pair inside
// uses the 32-step square root and the one-bit-per-cycle divider, next to
// one shared 32x32 multiplier. A last pair adds the final scaling, plus any
// out_stall. Reset clears the queue, the sums and the sticky saturation flag.
// A two-entry queue keeps taking pairs while it has room, also while the back
// end works or while the output item waits under out_stall.
module sph_viscosity_accumulate_core import svis_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int ACC_BITS  = 48
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [30:0]          cfg_data
);

    // reset values: 1.0 for mass, radius and gain; coefficient scaled from Q16.16
    localparam logic [30:0] ONE_FX      = 31'(64'd1 << FRAC_BITS);
    localparam logic [30:0] COEFF_RESET = 31'((64'd938722 << FRAC_BITS) >> 16);

    cfg_t     cfg_reg, cfg_next;
    logic     q_valid;
    logic     pop;
    q_entry_t q_head;

    // register file: take a write whenever the enable is high
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_en)
        begin
            case (cfg_index)
                CFG_MASS:   cfg_next.mass   = cfg_data;
                CFG_RADIUS: cfg_next.radius = cfg_data;
                CFG_GAIN:   cfg_next.gain   = cfg_data;
                CFG_COEFF:  cfg_next.coeff  = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mass   <= ONE_FX;
            cfg_reg.radius <= ONE_FX;
            cfg_reg.gain   <= ONE_FX;
            cfg_reg.coeff  <= COEFF_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept, split sign from magnitude, queue
    svis_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_head   (q_head)
    );

    // back: kernel terms, running sums, final scaling, output register
    svis_back #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sv/svis_check.sv */
// svis_check: port-level checks for the SPH viscosity accumulator, bound to
// the top level. Depends on svis_pkg and sph_viscosity_accumulate_core.
module svis_check import svis_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a held output item keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output item changed while stalled");

    // saturation is symmetric: the most negative code never shows
    a_sym_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.acc_x != 32'sh8000_0000
                   && out_data.acc_y != 32'sh8000_0000
                   && out_data.acc_z != 32'sh8000_0000)
        else $error("result outside symmetric range");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

    // the queue is empty after reset, so the input is not stalled
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_stall)
        else $error("input stalled right after reset");

endmodule

bind sph_viscosity_accumulate_core svis_check u_svis_check (.*);

/* tb/tb_sph_viscosity_accumulate_core.sv */
// Self-checking testbench for sph_viscosity_accumulate_core: random and directed
// neighbor pairs, an in-bench fixed-point predictor, scoreboard on the output item.
// Depends on svis_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_sph_viscosity_accumulate_core;
    import svis_pkg::*;

    localparam int          FRAC     = 16;
    localparam int          ACCW     = 48;
    localparam int          WD_LIMIT = 20000;  // cycles with no item moving
    localparam int          SETTLE   = 400;    // back-end drain before a register write
    localparam logic [63:0] CAP      = 64'h7FFF_FFFF;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MASS;
    logic [30:0]          cfg_data = '0;

    sph_viscosity_accumulate_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow registers and accumulator state of the predictor
    logic [63:0] mass_r, radius_r, gain_r, coeff_r;
    longint      vsum [3];
    bit          sat_sticky;
    bit          sat_now;

    in_item_t    pair_queue [$];
    out_item_t   accel_expected [$];
    int          errors = 0;
    bit          calm = 1'b0;
    int          gap_cnt = 0;
    int          stall_cnt = 0;
    int          idle_cycles = 0;

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 3);
    endfunction

    // --------------------------------------------------------------------
    // Fixed-point predictor
    // --------------------------------------------------------------------
    function automatic logic [63:0] cap31(logic [63:0] v);
        if (v > CAP)
        begin
            sat_now = 1'b1;
            return CAP;
        end
        return v;
    endfunction

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] magnitude(logic [31:0] raw);
        return raw[31] ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    endfunction

    // One axis of mass * dv / rho_n * w, symmetric saturation
    function automatic longint axis_term(logic [31:0] dv, logic [63:0] rho, logic [63:0] w);
        logic [63:0] mag, t1, t2, t3;
        mag = magnitude(dv);
        t1  = cap31((mass_r * mag) >> FRAC);
        if (rho == 0)
        begin
            sat_now = 1'b1;
            t2 = (mag != 0) ? CAP : 64'd0;
        end
        else
            t2 = cap31((t1 << FRAC) / rho);
        t3 = cap31((t2 * w) >> FRAC);
        return dv[31] ? -longint'(t3) : longint'(t3);
    endfunction

    function automatic longint sum_add(longint s, longint t);
        longint mx, mn;
        mx = (longint'(1) <<< (ACCW - 1)) - 1;
        mn = -mx - 1;
        if (t > 0 && s > mx - t)
        begin
            sat_now = 1'b1;
            return mx;
        end
        if (t < 0 && s < mn - t)
        begin
            sat_now = 1'b1;
            return mn;
        end
        return s + t;
    endfunction

    // Scale one axis of the sum by mu / rho_self
    function automatic logic [31:0] scale_axis(longint s, logic [63:0] rho);
        logic [63:0] mag, q, x, y, lim, hi, p, r;
        bit          neg;
        neg = s < 0;
        mag = neg ? (64'd0 - 64'(s)) : 64'(s);
        if (rho == 0)
        begin
            sat_now = 1'b1;
            q = (mag != 0) ? CAP : 64'd0;
        end
        else
        begin
            x   = (mag >> 32) * gain_r;
            y   = {32'd0, mag[31:0]} * gain_r;
            lim = rho << (31 - FRAC);
            q   = CAP;
            if (x > (64'hFFFF_FFFF_FFFF_FFFF >> (32 - FRAC)))
                sat_now = 1'b1;
            else
            begin
                hi = x << (32 - FRAC);
                p  = hi + (y >> FRAC);
                if (p < hi || p >= lim)
                    sat_now = 1'b1;
                else
                    q = (p << FRAC) / rho;
            end
        end
        r = neg ? (64'd0 - q) : q;
        return r[31:0];
    endfunction

    // Advance the predictor by one accepted pair; queue the acceleration on the last one
    task automatic predict_viscosity(in_item_t p);
        logic [63:0] ax, ay, az, r2, h2, d, w, rho_n;
        longint      t [3];
        out_item_t   acc;
        ax    = magnitude(p.rel_x);
        ay    = magnitude(p.rel_y);
        az    = magnitude(p.rel_z);
        rho_n = {33'd0, p.density_nb};
        r2    = ax * ax + ay * ay + az * az;
        h2    = radius_r * radius_r;
        sat_now = 1'b0;
        if (r2 < h2)
        begin
            d    = radius_r - isqrt(r2);
            w    = cap31((coeff_r * d) >> FRAC);
            t[0] = axis_term(p.dvel_x, rho_n, w);
            t[1] = axis_term(p.dvel_y, rho_n, w);
            t[2] = axis_term(p.dvel_z, rho_n, w);
            for (int i = 0; i < 3; i++)
                vsum[i] = sum_add(vsum[i], t[i]);
        end
        if (sat_now)
            sat_sticky = 1'b1;
        if (p.last_pair)
        begin
            sat_now       = 1'b0;
            acc.acc_x     = scale_axis(vsum[0], {33'd0, p.density_self});
            acc.acc_y     = scale_axis(vsum[1], {33'd0, p.density_self});
            acc.acc_z     = scale_axis(vsum[2], {33'd0, p.density_self});
            acc.saturated = sat_now | sat_sticky;
            accel_expected.push_back(acc);
            for (int i = 0; i < 3; i++)
                vsum[i] = 0;
            sat_sticky = 1'b0;
        end
    endtask

    // --------------------------------------------------------------------
    // Driver: present queued pairs with random gaps; predict on acceptance
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_viscosity(in_data);
                void'(pair_queue.pop_front());
                gap_cnt = draw_gap();
            end
            // hold a stalled item; otherwise advance to the next one
            if (!in_valid || !in_stall)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt--;
                    in_valid <= 1'b0;
                end
                else if (pair_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pair_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------------
    // Monitor: random out_stall, scoreboard, no-progress watchdog
    // --------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (accel_expected.size() == 0)
                    report("unexpected item", out_data.acc_x, 32'd0);
                else
                begin
                    if (out_data.acc_x !== accel_expected[0].acc_x)
                        report("acc_x", out_data.acc_x, accel_expected[0].acc_x);
                    if (out_data.acc_y !== accel_expected[0].acc_y)
                        report("acc_y", out_data.acc_y, accel_expected[0].acc_y);
                    if (out_data.acc_z !== accel_expected[0].acc_z)
                        report("acc_z", out_data.acc_z, accel_expected[0].acc_z);
                    if (out_data.saturated !== accel_expected[0].saturated)
                        report("saturated", {31'd0, out_data.saturated},
                               {31'd0, accel_expected[0].saturated});
                    void'(accel_expected.pop_front());
                end
                stall_cnt = draw_gap();
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;

            // any handshake counts as progress
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WD_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", WD_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // Stimulus
    // --------------------------------------------------------------------
    function automatic logic [31:0] near(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [30:0] rand_density();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return 31'($urandom);
            default: return 31'($urandom_range(1 << 14, 1 << 19));
        endcase
    endfunction

    function automatic logic [31:0] rand_dvel();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'd0;
            default: return near(1 << 18);
        endcase
    endfunction

    // Mostly pairs inside the support of radius h, some on the edge, some raw noise
    function automatic in_item_t rand_pair(logic [63:0] h, bit last);
        in_item_t    p;
        int unsigned span;
        span = h[31:0] >> 1;
        p.dvel_x       = rand_dvel();
        p.dvel_y       = rand_dvel();
        p.dvel_z       = rand_dvel();
        p.density_nb   = rand_density();
        p.density_self = rand_density();
        p.last_pair    = last;
        case ($urandom_range(0, 9))
            0:
            begin
                p.rel_x = $urandom;
                p.rel_y = $urandom;
                p.rel_z = $urandom;
            end
            1:
            begin
                // exactly on the support boundary: contributes nothing
                p.rel_x = $urandom_range(0, 1) ? h[31:0] : -h[31:0];
                p.rel_y = 32'd0;
                p.rel_z = 32'd0;
            end
            default:
            begin
                p.rel_x = near(span);
                p.rel_y = near(span);
                p.rel_z = near(span);
            end
        endcase
        return p;
    endfunction

    task automatic push_pair(logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [30:0] rn, logic [30:0] rs, bit last);
        in_item_t p;
        p = '{rx, ry, rz, vx, vy, vz, rn, rs, last};
        pair_queue.push_back(p);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
        @(posedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_en    <= 1'b0;
        case (idx)
            CFG_MASS:   mass_r   = {33'd0, val};
            CFG_RADIUS: radius_r = {33'd0, val};
            CFG_GAIN:   gain_r   = {33'd0, val};
            default:    coeff_r  = {33'd0, val};
        endcase
    endtask

    task automatic set_config(logic [30:0] m, logic [30:0] h, logic [30:0] g, logic [30:0] c);
        write_reg(CFG_MASS, m);
        write_reg(CFG_RADIUS, h);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_COEFF, c);
    endtask

    // Wait until every queued pair is taken and every acceleration seen, then drain
    task automatic drain();
        while (pair_queue.size() != 0 || in_valid || accel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Random particles: each a run of 1..6 neighbor pairs, the last one marked
    task automatic random_phase(int n_pairs);
        int sent;
        int nb;
        sent = 0;
        while (sent < n_pairs)
        begin
            nb = $urandom_range(1, 6);
            @(negedge clk);
            for (int k = 0; k < nb; k++)
                pair_queue.push_back(rand_pair(radius_r, k == nb - 1));
            sent += nb;
            while (pair_queue.size() > 8)
                @(negedge clk);
        end
    endtask

    initial
    begin
        mass_r     = 64'd65536;
        radius_r   = 64'd65536;
        gain_r     = 64'd65536;
        coeff_r    = 64'd938722;
        sat_sticky = 1'b0;
        for (int i = 0; i < 3; i++)
            vsum[i] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pairs at reset settings (h = 1.0)
        push_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 31'h7FFF_FFFF, 31'h10000, 1);
        push_pair(0, 0, 0, 32'h10000, -32'h10000, 0, 0, 31'h10000, 1);   // zero rho_n
        push_pair(0, 0, 0, 0, 0, 0, 0, 31'h10000, 1);                    // zero rho_n, dv 0
        push_pair(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 31'h10000, 1);    // on boundary
        push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h10000, 0, 0, 31'h10000, 31'h10000, 1);             // most negative rel
        push_pair(32'h4000, 32'h4000, -32'h4000, 32'h20000, 32'h30000, -32'h8000,
                  31'h10000, 0, 1);                                      // zero rho_self
        push_pair(0, 0, 0, 0, 0, 0, 31'h10000, 0, 1);                    // zero sum, rho_self 0
        push_pair(32'h100, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  31'd1, 31'd1, 0);                                      // huge terms
        push_pair(32'h100, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  31'd1, 31'd1, 0);
        push_pair(0, 32'h7FFF_FFFF, 0, 32'h1234, 0, 0, 31'h10000, 31'd1, 1);
        push_pair(32'h2000, 32'h1000, 32'h800, -32'h50000, 32'h60000, 32'h1,
                  31'h18000, 31'h7FFF_FFFF, 0);
        push_pair(-32'h2000, -32'h1000, -32'h800, 32'h50000, -32'h60000, -32'h1,
                  31'h8000, 31'h20000, 1);
        drain();

        calm = 1'b0;
        random_phase(240);
        drain();

        // Minimum settings: h = 1 lsb, only coincident pairs inside
        set_config(31'd1, 31'd1, 31'd0, 31'd0);
        push_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h1, 32'h8000_0000, 31'd1, 31'd1, 1);
        calm = 1'b1;
        random_phase(200);
        drain();

        // Maximum settings
        set_config(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_pair(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 1);
        calm = 1'b0;
        random_phase(200);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_config(31'($urandom_range(1 << 12, 1 << 20)),
                       31'($urandom_range(1 << 10, 1 << 22)),
                       ph == 0 ? 31'($urandom) : 31'($urandom_range(0, 1 << 20)),
                       ph == 1 ? 31'($urandom) : 31'($urandom_range(0, 1 << 24)));
            calm = (ph == 2);
            random_phase(200);
            drain();
        end

        if (accel_expected.size() != 0)
            report("items never produced", accel_expected.size(), 32'd0);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sph_viscosity_accumulate_core.f */
sv/svis_pkg.sv
sv/svis_front.sv
sv/svis_sqrt.sv
sv/svis_div.sv
sv/svis_back.sv
sv/sph_viscosity_accumulate_core.sv
sv/svis_check.sv
tb/tb_sph_viscosity_accumulate_core.sv
